// ===== src/vbf_dijet_event_selector_core_macros.svh =====
// Assertion helpers shared by the selector modules
`ifndef VBF_DIJET_EVENT_SELECTOR_CORE_MACROS_SVH
`define VBF_DIJET_EVENT_SELECTOR_CORE_MACROS_SVH

// same-cycle implication
`define VDES_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VDES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/vdes_pkg.sv =====
package vdes_pkg;

   localparam int MOM_W       = 16;
   localparam int ETA_W       = 12;
   localparam int ETA_DIFF_W  = ETA_W + 1;
   localparam int PROD_W      = 2 * MOM_W;
   localparam int PT_SQ_W     = PROD_W + 1;
   localparam int SUM_W       = MOM_W + 1;
   localparam int SQ_W        = 2 * SUM_W;
   localparam int MASS_W      = SQ_W + 3;
   localparam int WIDE_W      = 64;

   localparam int MET_MIN_W   = 34;
   localparam int PT_MIN_W    = 34;
   localparam int GAP_MIN_W   = 12;
   localparam int MASS_MIN_W  = 36;
   localparam int CSR_DATA_W  = 36;
   localparam int CSR_IDX_W   = 2;
   localparam int LEVEL_W     = 3;

   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);
   localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_MET_MIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PT_MIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS_MIN = 2'd3;

   localparam logic [MET_MIN_W-1:0]  MET_MIN_RST  = 34'd640000;
   localparam logic [PT_MIN_W-1:0]   PT_MIN_RST   = 34'd57600;
   localparam logic [GAP_MIN_W-1:0]  GAP_MIN_RST  = 12'd1024;
   localparam logic [MASS_MIN_W-1:0] MASS_MIN_RST = 36'd64000000;

   typedef enum logic [LEVEL_W-1:0] {
      LVL_FAIL    = 3'd0,
      LVL_PRESEL  = 3'd1,
      LVL_TAG_PT  = 3'd2,
      LVL_ETA_GAP = 3'd3,
      LVL_MASS    = 3'd4,
      LVL_VETO    = 3'd5
   } level_type;

   typedef struct packed {
      logic [MET_MIN_W-1:0]  met_min_sq;
      logic [PT_MIN_W-1:0]   jet_pt_min_sq;
      logic [GAP_MIN_W-1:0]  eta_gap_min;
      logic [MASS_MIN_W-1:0] mass_min_sq;
   } cfg_type;

   // classified jet item handed from front to back
   typedef struct packed {
      logic                    start;
      logic                    last;
      logic                    present;
      logic signed [MOM_W-1:0] px;
      logic signed [MOM_W-1:0] py;
      logic signed [MOM_W-1:0] pz;
      logic [MOM_W-1:0]        energy;
      logic signed [ETA_W-1:0] eta;
      logic                    met_ok;
      logic                    pt_ok;
   } item_type;

   typedef struct packed {
      logic pair;
      logic met_ok;
      logic tags_ok;
      logic veto;
   } flags_type;

endpackage

// ===== src/vdes_front.sv =====
`include "vbf_dijet_event_selector_core_macros.svh"

module vdes_front (
   input  logic                           clock,
   input  logic                           reset,
   input  vdes_pkg::cfg_type              cfg,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_event_start,
   input  logic                           req_event_end,
   input  logic                           req_jet_present,
   input  logic signed [vdes_pkg::MOM_W-1:0] req_jet_px,
   input  logic signed [vdes_pkg::MOM_W-1:0] req_jet_py,
   input  logic signed [vdes_pkg::MOM_W-1:0] req_jet_pz,
   input  logic [vdes_pkg::MOM_W-1:0]     req_jet_energy,
   input  logic signed [vdes_pkg::ETA_W-1:0] req_jet_eta,
   input  logic signed [vdes_pkg::MOM_W-1:0] req_met_px,
   input  logic signed [vdes_pkg::MOM_W-1:0] req_met_py,
   output logic                           push_valid,
   input  logic                           push_ready,
   output vdes_pkg::item_type             push_item
);
   import vdes_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   item_type                 s1_item_ff;
   logic [PROD_W-1:0]        s1_px2_ff, s1_py2_ff, s1_mx2_ff, s1_my2_ff;
   logic                     s2_valid_ff, s2_valid_in;
   item_type                 s2_item_ff, s2_item_in;
   logic                     s1_ready, s2_ready;
   logic signed [PROD_W-1:0] px2, py2, mx2, my2;
   logic [PT_SQ_W-1:0]       pt_sq, met_sq;

   assign s2_ready  = !s2_valid_ff || push_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign px2 = req_jet_px * req_jet_px;
   assign py2 = req_jet_py * req_jet_py;
   assign mx2 = req_met_px * req_met_px;
   assign my2 = req_met_py * req_met_py;

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      pt_sq              = PT_SQ_W'(s1_px2_ff) + PT_SQ_W'(s1_py2_ff);
      met_sq             = PT_SQ_W'(s1_mx2_ff) + PT_SQ_W'(s1_my2_ff);
      s2_item_in         = s1_item_ff;
      s2_item_in.pt_ok   = WIDE_W'(pt_sq) > WIDE_W'(cfg.jet_pt_min_sq);
      s2_item_in.met_ok  = WIDE_W'(met_sq) > WIDE_W'(cfg.met_min_sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_item_ff.start   <= req_event_start;
         s1_item_ff.last    <= req_event_end;
         s1_item_ff.present <= req_jet_present;
         s1_item_ff.px      <= req_jet_px;
         s1_item_ff.py      <= req_jet_py;
         s1_item_ff.pz      <= req_jet_pz;
         s1_item_ff.energy  <= req_jet_energy;
         s1_item_ff.eta     <= req_jet_eta;
         s1_item_ff.met_ok  <= 1'b0;
         s1_item_ff.pt_ok   <= 1'b0;
         s1_px2_ff          <= $unsigned(px2);
         s1_py2_ff          <= $unsigned(py2);
         s1_mx2_ff          <= $unsigned(mx2);
         s1_my2_ff          <= $unsigned(my2);
      end
      if (s1_valid_ff && s2_ready) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign push_valid = s2_valid_ff;
   assign push_item  = s2_item_ff;

   `VDES_ASSERT_NEXT(a_front_s1_hold, clock, reset, s1_valid_ff && !s2_ready,
      s1_valid_ff, "front stage lost an item while blocked")
   `VDES_ASSERT_NEXT(a_front_s2_fill, clock, reset, s1_valid_ff && s2_ready,
      s2_valid_ff, "front item did not reach second stage")

endmodule

// ===== src/vdes_queue.sv =====
`include "vbf_dijet_event_selector_core_macros.svh"

module vdes_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  vdes_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output vdes_pkg::item_type pop_item
);
   import vdes_pkg::*;

   item_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = count_ff != Q_CNT_W'(Q_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `VDES_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1,
      count_ff <= Q_CNT_W'(Q_DEPTH), "item queue overfilled")

endmodule

// ===== src/vdes_back.sv =====
`include "vbf_dijet_event_selector_core_macros.svh"

module vdes_back (
   input  logic                              clock,
   input  logic                              reset,
   input  vdes_pkg::cfg_type                 cfg,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  vdes_pkg::item_type                pop_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vdes_pkg::LEVEL_W-1:0]      rsp_pass_level,
   output logic [vdes_pkg::ETA_W-1:0]        rsp_eta_gap,
   output logic signed [vdes_pkg::MASS_W-1:0] rsp_dijet_mass_sq
);
   import vdes_pkg::*;

   // event state
   logic [1:0]              jet_count_ff, jet_count_in;
   logic                    met_ok_ff, met_ok_in;
   logic signed [MOM_W-1:0] lead_px_ff, lead_px_in, lead_py_ff, lead_py_in;
   logic signed [MOM_W-1:0] lead_pz_ff, lead_pz_in;
   logic [MOM_W-1:0]        lead_energy_ff, lead_energy_in;
   logic signed [ETA_W-1:0] lead_eta_ff, lead_eta_in;
   logic                    lead_pt_ok_ff, lead_pt_ok_in;
   logic signed [MOM_W-1:0] sec_px_ff, sec_px_in, sec_py_ff, sec_py_in;
   logic signed [MOM_W-1:0] sec_pz_ff, sec_pz_in;
   logic [MOM_W-1:0]        sec_energy_ff, sec_energy_in;
   logic signed [ETA_W-1:0] sec_eta_ff, sec_eta_in;
   logic                    sec_pt_ok_ff, sec_pt_ok_in;
   logic                    veto_hit_ff, veto_hit_in;

   // result pipeline
   logic                    r1_valid_ff, r2_valid_ff, r3_valid_ff, out_valid_ff;
   flags_type               r1_flags_ff, r1_flags_in, r2_flags_ff, r3_flags_ff;
   logic [SUM_W-1:0]        r1_se_ff;
   logic signed [SUM_W-1:0] r1_sx_ff, r1_sy_ff, r1_sz_ff;
   logic signed [ETA_W-1:0] r1_eta_a_ff, r1_eta_b_ff;
   logic [SQ_W-1:0]         r2_se2_ff, r2_sx2_ff, r2_sy2_ff, r2_sz2_ff;
   logic [ETA_W-1:0]        r2_gap_ff, r2_gap_in, r3_gap_ff;
   logic                    r2_gap_ok_ff, r2_gap_ok_in, r3_gap_ok_ff;
   logic signed [MASS_W-1:0] r3_mass_ff, r3_mass_in;
   logic [LEVEL_W-1:0]      out_level_ff;
   level_type               out_level_in;
   logic [ETA_W-1:0]        out_gap_ff;
   logic signed [MASS_W-1:0] out_mass_ff;

   logic                    take, between, mass_ok;
   logic                    out_ready, r3_ready, r2_ready, r1_ready;
   logic signed [ETA_DIFF_W-1:0] eta_diff;
   logic signed [SQ_W-1:0]  sx2, sy2, sz2;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign r3_ready  = !r3_valid_ff || out_ready;
   assign r2_ready  = !r2_valid_ff || r3_ready;
   assign r1_ready  = !r1_valid_ff || r2_ready;
   assign pop_ready = r1_ready;
   assign take      = pop_valid && pop_ready;

   assign between = (pop_item.eta > lead_eta_ff && pop_item.eta < sec_eta_ff) ||
                    (pop_item.eta > sec_eta_ff && pop_item.eta < lead_eta_ff);

   always_comb begin
      jet_count_in   = jet_count_ff;
      met_ok_in      = met_ok_ff;
      lead_px_in     = lead_px_ff;
      lead_py_in     = lead_py_ff;
      lead_pz_in     = lead_pz_ff;
      lead_energy_in = lead_energy_ff;
      lead_eta_in    = lead_eta_ff;
      lead_pt_ok_in  = lead_pt_ok_ff;
      sec_px_in      = sec_px_ff;
      sec_py_in      = sec_py_ff;
      sec_pz_in      = sec_pz_ff;
      sec_energy_in  = sec_energy_ff;
      sec_eta_in     = sec_eta_ff;
      sec_pt_ok_in   = sec_pt_ok_ff;
      veto_hit_in    = veto_hit_ff;
      if (pop_item.start) begin
         met_ok_in     = pop_item.met_ok;
         jet_count_in  = 2'd0;
         lead_pt_ok_in = 1'b0;
         sec_pt_ok_in  = 1'b0;
         veto_hit_in   = 1'b0;
      end
      if (pop_item.present) begin
         case (jet_count_in)
            2'd0: begin
               lead_px_in     = pop_item.px;
               lead_py_in     = pop_item.py;
               lead_pz_in     = pop_item.pz;
               lead_energy_in = pop_item.energy;
               lead_eta_in    = pop_item.eta;
               lead_pt_ok_in  = pop_item.pt_ok;
               jet_count_in   = 2'd1;
            end
            2'd1: begin
               sec_px_in     = pop_item.px;
               sec_py_in     = pop_item.py;
               sec_pz_in     = pop_item.pz;
               sec_energy_in = pop_item.energy;
               sec_eta_in    = pop_item.eta;
               sec_pt_ok_in  = pop_item.pt_ok;
               jet_count_in  = 2'd2;
            end
            default: begin
               if (pop_item.pt_ok && between) begin
                  veto_hit_in = 1'b1;
               end
            end
         endcase
      end
      r1_flags_in.pair    = jet_count_in == 2'd2;
      r1_flags_in.met_ok  = met_ok_in;
      r1_flags_in.tags_ok = lead_pt_ok_in && sec_pt_ok_in;
      r1_flags_in.veto    = veto_hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jet_count_ff   <= 2'd0;
         met_ok_ff      <= 1'b0;
         lead_px_ff     <= '0;
         lead_py_ff     <= '0;
         lead_pz_ff     <= '0;
         lead_energy_ff <= '0;
         lead_eta_ff    <= '0;
         lead_pt_ok_ff  <= 1'b0;
         sec_px_ff      <= '0;
         sec_py_ff      <= '0;
         sec_pz_ff      <= '0;
         sec_energy_ff  <= '0;
         sec_eta_ff     <= '0;
         sec_pt_ok_ff   <= 1'b0;
         veto_hit_ff    <= 1'b0;
      end else if (take) begin
         jet_count_ff   <= jet_count_in;
         met_ok_ff      <= met_ok_in;
         lead_px_ff     <= lead_px_in;
         lead_py_ff     <= lead_py_in;
         lead_pz_ff     <= lead_pz_in;
         lead_energy_ff <= lead_energy_in;
         lead_eta_ff    <= lead_eta_in;
         lead_pt_ok_ff  <= lead_pt_ok_in;
         sec_px_ff      <= sec_px_in;
         sec_py_ff      <= sec_py_in;
         sec_pz_ff      <= sec_pz_in;
         sec_energy_ff  <= sec_energy_in;
         sec_eta_ff     <= sec_eta_in;
         sec_pt_ok_ff   <= sec_pt_ok_in;
         veto_hit_ff    <= veto_hit_in;
      end
   end

   // stage 2 combinational: squares and eta gap
   assign sx2 = r1_sx_ff * r1_sx_ff;
   assign sy2 = r1_sy_ff * r1_sy_ff;
   assign sz2 = r1_sz_ff * r1_sz_ff;

   always_comb begin
      eta_diff     = ETA_DIFF_W'(r1_eta_a_ff) - ETA_DIFF_W'(r1_eta_b_ff);
      if (eta_diff[ETA_DIFF_W-1]) begin
         eta_diff = -eta_diff;
      end
      r2_gap_in    = r1_flags_ff.pair ? eta_diff[ETA_W-1:0] : '0;
      r2_gap_ok_in = WIDE_W'(r2_gap_in) > WIDE_W'(cfg.eta_gap_min);
   end

   // stage 3 combinational: mass squared
   always_comb begin
      r3_mass_in = $signed(MASS_W'(r2_se2_ff) - MASS_W'(r2_sx2_ff)
                          - (MASS_W'(r2_sy2_ff) + MASS_W'(r2_sz2_ff)));
      if (!r2_flags_ff.pair) begin
         r3_mass_in = '0;
      end
   end

   // output stage combinational: cut cascade
   always_comb begin
      mass_ok      = !r3_mass_ff[MASS_W-1] &&
                     WIDE_W'(r3_mass_ff[MASS_W-2:0]) > WIDE_W'(cfg.mass_min_sq);
      out_level_in = LVL_FAIL;
      if (r3_flags_ff.pair && r3_flags_ff.met_ok) begin
         out_level_in = LVL_PRESEL;
         if (r3_flags_ff.tags_ok) begin
            out_level_in = LVL_TAG_PT;
            if (r3_gap_ok_ff) begin
               out_level_in = LVL_ETA_GAP;
               if (mass_ok) begin
                  out_level_in = LVL_MASS;
                  if (!r3_flags_ff.veto) begin
                     out_level_in = LVL_VETO;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff  <= 1'b0;
         r2_valid_ff  <= 1'b0;
         r3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (r1_ready) begin
            r1_valid_ff <= take && pop_item.last;
         end
         if (r2_ready) begin
            r2_valid_ff <= r1_valid_ff;
         end
         if (r3_ready) begin
            r3_valid_ff <= r2_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= r3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && pop_item.last) begin
         r1_flags_ff <= r1_flags_in;
         r1_se_ff    <= SUM_W'(lead_energy_in) + SUM_W'(sec_energy_in);
         r1_sx_ff    <= SUM_W'(lead_px_in) + SUM_W'(sec_px_in);
         r1_sy_ff    <= SUM_W'(lead_py_in) + SUM_W'(sec_py_in);
         r1_sz_ff    <= SUM_W'(lead_pz_in) + SUM_W'(sec_pz_in);
         r1_eta_a_ff <= lead_eta_in;
         r1_eta_b_ff <= sec_eta_in;
      end
      if (r1_valid_ff && r2_ready) begin
         r2_flags_ff  <= r1_flags_ff;
         r2_se2_ff    <= r1_se_ff * r1_se_ff;
         r2_sx2_ff    <= $unsigned(sx2);
         r2_sy2_ff    <= $unsigned(sy2);
         r2_sz2_ff    <= $unsigned(sz2);
         r2_gap_ff    <= r2_gap_in;
         r2_gap_ok_ff <= r2_gap_ok_in;
      end
      if (r2_valid_ff && r3_ready) begin
         r3_flags_ff  <= r2_flags_ff;
         r3_mass_ff   <= r3_mass_in;
         r3_gap_ff    <= r2_gap_ff;
         r3_gap_ok_ff <= r2_gap_ok_ff;
      end
      if (r3_valid_ff && out_ready) begin
         out_level_ff <= out_level_in;
         out_gap_ff   <= r3_gap_ff;
         out_mass_ff  <= r3_mass_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pass_level    = out_level_ff;
   assign rsp_eta_gap       = out_gap_ff;
   assign rsp_dijet_mass_sq = out_mass_ff;

   `VDES_ASSERT_NOW(a_back_count_sat, clock, reset, 1'b1,
      jet_count_ff != 2'd3, "jet count went past two")
   `VDES_ASSERT_NEXT(a_back_end_result, clock, reset, take && pop_item.last,
      r1_valid_ff, "end item produced no result")

endmodule

// ===== src/vbf_dijet_event_selector_core.sv =====
// Dijet event selector. Jets of one event enter on the req_ channel one item
// per cycle, with start/end marks; missing momentum is read on the start item.
// On the end item one result leaves on the rsp_ channel: the cut level reached,
// the tag-jet eta gap and the tag-pair mass squared. Other items give none.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Thresholds are written through csr_write/csr_index/csr_data while idle.
// Throughput: one item per cycle while rsp_stall is low. A front pipeline of
// two stages squares the jet and missing momenta and compares them; a
// four-entry queue decouples it from the back, which updates the event state
// one item a cycle while its result stages can move and runs the result
// through them (sums, squares, mass, cuts), registered in that order. When
// rsp_stall is held the result stages fill, then the queue and the front
// stages, then req_stall rises; nothing is dropped. Reset (synchronous,
// active high) empties the pipelines and queue, clears the event state and
// restores the default thresholds (100 GeV, 30 GeV, 4.0, 1000 GeV).
module vbf_dijet_event_selector_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [vdes_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vdes_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_event_start,
   input  logic                               req_event_end,
   input  logic                               req_jet_present,
   input  logic signed [vdes_pkg::MOM_W-1:0]  req_jet_px,
   input  logic signed [vdes_pkg::MOM_W-1:0]  req_jet_py,
   input  logic signed [vdes_pkg::MOM_W-1:0]  req_jet_pz,
   input  logic [vdes_pkg::MOM_W-1:0]         req_jet_energy,
   input  logic signed [vdes_pkg::ETA_W-1:0]  req_jet_eta,
   input  logic signed [vdes_pkg::MOM_W-1:0]  req_met_px,
   input  logic signed [vdes_pkg::MOM_W-1:0]  req_met_py,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [vdes_pkg::LEVEL_W-1:0]       rsp_pass_level,
   output logic [vdes_pkg::ETA_W-1:0]         rsp_eta_gap,
   output logic signed [vdes_pkg::MASS_W-1:0] rsp_dijet_mass_sq
);
   import vdes_pkg::*;

   cfg_type  cfg_ff;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.met_min_sq    <= MET_MIN_RST;
         cfg_ff.jet_pt_min_sq <= PT_MIN_RST;
         cfg_ff.eta_gap_min   <= GAP_MIN_RST;
         cfg_ff.mass_min_sq   <= MASS_MIN_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MET_MIN:  cfg_ff.met_min_sq    <= csr_data[MET_MIN_W-1:0];
            CSR_PT_MIN:   cfg_ff.jet_pt_min_sq <= csr_data[PT_MIN_W-1:0];
            CSR_GAP_MIN:  cfg_ff.eta_gap_min   <= csr_data[GAP_MIN_W-1:0];
            CSR_MASS_MIN: cfg_ff.mass_min_sq   <= csr_data[MASS_MIN_W-1:0];
            default: ;
         endcase
      end
   end

   vdes_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_event_start (req_event_start),
      .req_event_end   (req_event_end),
      .req_jet_present (req_jet_present),
      .req_jet_px      (req_jet_px),
      .req_jet_py      (req_jet_py),
      .req_jet_pz      (req_jet_pz),
      .req_jet_energy  (req_jet_energy),
      .req_jet_eta     (req_jet_eta),
      .req_met_px      (req_met_px),
      .req_met_py      (req_met_py),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   vdes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   vdes_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_item          (pop_item),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pass_level    (rsp_pass_level),
      .rsp_eta_gap       (rsp_eta_gap),
      .rsp_dijet_mass_sq (rsp_dijet_mass_sq)
   );

endmodule
